[rtl/eye_blink_animation_renderer_macros.svh]
// ----------------------------------------------------------------------------
// Eye blink renderer assertion macros
// Shared property shorthands for the renderer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef EYE_BLINK_ANIMATION_RENDERER_MACROS_SVH
`define EYE_BLINK_ANIMATION_RENDERER_MACROS_SVH

// same-cycle implication, disabled in reset
`define EBAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eye blink renderer check failed");

// next-cycle implication, disabled in reset
`define EBAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eye blink renderer check failed");

`endif

[rtl/ebar_pkg.sv]
// ----------------------------------------------------------------------------
// Eye blink renderer package
// Types, operation codes and register indexes of the eye blink renderer.
// ----------------------------------------------------------------------------
package ebar_pkg;

  localparam int COLUMNS = 32;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] CONTRACT_LEAD = 16'd150;

  localparam logic [1:0] FN_BEGIN  = 2'd0;
  localparam logic [1:0] FN_TOUCH  = 2'd1;
  localparam logic [1:0] FN_UPDATE = 2'd2;
  localparam logic [1:0] FN_RENDER = 2'd3;

  localparam logic [1:0] GZ_LEFT  = 2'd1;
  localparam logic [1:0] GZ_RIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREET_OPEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREET_HOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREET_CLOSE = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPENING,
    PH_OPEN,
    PH_CLOSING,
    PH_FINISHED
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SETUP,
    S_DIVIDE,
    S_START,
    S_EMIT
  } seq_state_t;

endpackage

[rtl/eye_blink_animation_renderer.sv]
// ----------------------------------------------------------------------------
// Eye blink animation renderer
// Phase sequencer, clip divider and row generator for a 16-row eye matrix.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; in_tready is high only while the block is
// idle. Begin and touch complete in the cycle they are taken. An update forms
// elapsed time on acceptance and steps the phase in the next cycle. A render
// then adds a setup state, the steps of the shared compare-subtract divider
// that work out the clip rows (skipped when no clip applies), a load state and
// then sixteen row results, one per cycle while out_tready stays high. The row
// unit draws all columns of one row per cycle, so the output rate sets the
// tail of a render.
`include "eye_blink_animation_renderer_macros.svh"

module eye_blink_animation_renderer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // gaze[1:0], greeting[2], random_bits[5:3], now_ms[37:6], zero pad [39:38]
  input  logic [ebar_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [ebar_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row_index[3:0], pixel_row[35:4], zero pad [39:36]
  output logic [ebar_pkg::OUT_DATA_W-1:0] out_tdata,
  // active[0]
  output logic [ebar_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ebar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebar_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ebar_pkg::*;

  // configuration
  logic [15:0] open_r, hold_r, close_r, gopen_r, ghold_r, gclose_r;

  // animation state
  phase_t            phase_r, phase_nxt;
  logic [1:0]        gaze_r, gaze_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [2:0]        radius_r, radius_nxt;
  logic signed [2:0] shift_r, shift_nxt;
  logic              greet_r, greet_nxt;
  logic              contracted_r, contracted_nxt;

  // sequencer and working registers
  seq_state_t  state_r, state_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        act_r, act_nxt;
  logic [3:0]  clip_r, clip_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] div_r, div_nxt;
  logic [3:0]  quo_r, quo_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [3:0]  row_r, row_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_row_r, out_row_nxt;
  logic [31:0] out_pix_r, out_pix_nxt;
  logic        out_act_r, out_act_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_acc, out_acc;
  logic [1:0]  in_func;
  logic [1:0]  in_gaze;
  logic        in_greet;
  logic [2:0]  in_rnd;
  logic [31:0] in_now;

  logic [15:0] dur_open, dur_hold, dur_close, dur_sel;
  logic        el_hi;
  logic        ge_open, ge_hold, ge_close, ge_sel, ge_lead;
  logic [16:0] trial;
  logic        trial_ge;
  logic [3:0]  load_row;
  logic [3:0]  load_bottom;
  logic [31:0] load_bits;

  assign in_func  = in_tuser[1:0];
  assign in_gaze  = in_tdata[1:0];
  assign in_greet = in_tdata[2];
  assign in_rnd   = in_tdata[5:3];
  assign in_now   = in_tdata[37:6];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_valid_r && out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pix_r, out_row_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  assign dur_open  = greet_r ? gopen_r  : open_r;
  assign dur_hold  = greet_r ? ghold_r  : hold_r;
  assign dur_close = greet_r ? gclose_r : close_r;
  assign dur_sel   = (phase_r == PH_OPENING) ? dur_open : dur_close;

  assign el_hi    = (elapsed_r[31:16] != 16'd0);
  assign ge_open  = el_hi || (elapsed_r[15:0] >= dur_open);
  assign ge_hold  = el_hi || (elapsed_r[15:0] >= dur_hold);
  assign ge_close = el_hi || (elapsed_r[15:0] >= dur_close);
  assign ge_sel   = el_hi || (elapsed_r[15:0] >= dur_sel);
  assign ge_lead  = (dur_hold >= CONTRACT_LEAD) &&
                    (el_hi || (elapsed_r[15:0] >= (dur_hold - CONTRACT_LEAD)));

  // shared compare-subtract step of the clip divider
  assign trial    = (step_r == 2'd0) ? rem_r : {rem_r[15:0], 1'b0};
  assign trial_ge = (trial >= {1'b0, div_r});

  function automatic logic [31:0] row_bits(logic [3:0] y, logic [1:0] gz,
                                           logic signed [2:0] sh, logic [2:0] rad);
    logic [31:0]        bits;
    logic signed [11:0] dx, dy, px, py, pcx, pcy, rr, s_eye, s_iris, s_pup;
    bits = 32'd0;
    case (gz)
      GZ_LEFT:  pcx = 12'sd12;
      GZ_RIGHT: pcx = 12'sd18;
      default:  pcx = 12'sd15;
    endcase
    pcy = 12'sd7 + 12'(sh);
    rr  = signed'({9'b0, rad}) * signed'({9'b0, rad});
    dy  = signed'({8'b0, y}) - 12'sd7;
    py  = signed'({8'b0, y}) - pcy;
    for (int x = 0; x < 32; x++) begin
      dx     = signed'(12'(x)) - 12'sd15;
      px     = signed'(12'(x)) - pcx;
      s_eye  = dx * dx + 12'sd4 * dy * dy;
      s_iris = dx * dx + dy * dy;
      s_pup  = px * px + py * py;
      if (x < COLUMNS) begin
        bits[x] = ((s_eye <= 12'sd196) && !(s_iris <= 12'sd36)) || (s_pup <= rr);
      end
    end
    return bits;
  endfunction

  assign load_row    = (state_r == S_EMIT) ? (row_r + 4'd1) : 4'd0;
  assign load_bottom = 4'd15 - clip_r;
  assign load_bits   = (act_r && (load_row >= clip_r) && (load_row <= load_bottom)) ?
                       row_bits(load_row, gaze_r, shift_r, radius_r) : 32'd0;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    gaze_nxt       = gaze_r;
    start_nxt      = start_r;
    radius_nxt     = radius_r;
    shift_nxt      = shift_r;
    greet_nxt      = greet_r;
    contracted_nxt = contracted_r;
    func_nxt       = func_r;
    now_nxt        = now_r;
    elapsed_nxt    = elapsed_r;
    act_nxt        = act_r;
    clip_nxt       = clip_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r;
    out_row_nxt    = out_row_r;
    out_pix_nxt    = out_pix_r;
    out_act_nxt    = out_act_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_BEGIN: begin
              gaze_nxt       = in_gaze;
              greet_nxt      = in_greet;
              phase_nxt      = PH_OPENING;
              start_nxt      = in_now;
              contracted_nxt = 1'b0;
              radius_nxt     = 3'd3 + {2'b0, in_rnd[0]};
              shift_nxt      = signed'({1'b0, in_rnd[2:1]}) - 3'sd1;
            end
            FN_TOUCH: begin
              gaze_nxt       = in_gaze;
              phase_nxt      = PH_OPENING;
              start_nxt      = in_now;
              contracted_nxt = 1'b0;
              if (greet_r && (radius_r < 3'd3)) begin
                radius_nxt = 3'd3;
              end
            end
            default: begin
              func_nxt    = in_func;
              now_nxt     = in_now;
              elapsed_nxt = in_now - start_r;
              state_nxt   = S_UPDATE;
            end
          endcase
        end
      end

      S_UPDATE: begin
        case (phase_r)
          PH_OPENING: begin
            if (ge_open) begin
              phase_nxt   = PH_OPEN;
              start_nxt   = now_r;
              elapsed_nxt = 32'd0;
            end
          end
          PH_OPEN: begin
            if (greet_r && !contracted_r && ge_lead) begin
              contracted_nxt = 1'b1;
              if (radius_r > 3'd2) begin
                radius_nxt = radius_r - 3'd1;
              end
            end
            if (ge_hold) begin
              phase_nxt   = PH_CLOSING;
              start_nxt   = now_r;
              elapsed_nxt = 32'd0;
            end
          end
          PH_CLOSING: begin
            if (ge_close) begin
              phase_nxt = PH_FINISHED;
            end
          end
          default: begin
          end
        endcase
        state_nxt = (func_r == FN_RENDER) ? S_SETUP : S_IDLE;
      end

      S_SETUP: begin
        act_nxt  = (phase_r == PH_OPENING) || (phase_r == PH_OPEN) ||
                   (phase_r == PH_CLOSING);
        clip_nxt = 4'd0;
        div_nxt  = dur_sel;
        step_nxt = 2'd0;
        quo_nxt  = 4'd0;
        if (phase_r == PH_OPENING) begin
          rem_nxt = ge_sel ? 17'd0 : {1'b0, dur_sel - elapsed_r[15:0]};
        end else begin
          rem_nxt = ge_sel ? {1'b0, dur_sel} : {1'b0, elapsed_r[15:0]};
        end
        if (((phase_r == PH_OPENING) || (phase_r == PH_CLOSING)) && (dur_sel != 16'd0)) begin
          state_nxt = S_DIVIDE;
        end else begin
          state_nxt = S_START;
        end
      end

      S_DIVIDE: begin
        rem_nxt  = trial_ge ? (trial - {1'b0, div_r}) : trial;
        quo_nxt  = {quo_r[2:0], trial_ge};
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          clip_nxt  = {quo_r[2:0], trial_ge};
          state_nxt = S_START;
        end
      end

      S_START: begin
        row_nxt       = 4'd0;
        out_valid_nxt = 1'b1;
        out_row_nxt   = load_row;
        out_pix_nxt   = load_bits;
        out_act_nxt   = act_r;
        out_last_nxt  = 1'b0;
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (out_acc) begin
          if (row_r == 4'd15) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            // advance to the next row
            row_nxt      = load_row;
            out_row_nxt  = load_row;
            out_pix_nxt  = load_bits;
            out_last_nxt = (load_row == 4'd15);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_IDLE;
      gaze_r       <= 2'd0;
      start_r      <= 32'd0;
      radius_r     <= 3'd3;
      shift_r      <= 3'sd0;
      greet_r      <= 1'b0;
      contracted_r <= 1'b0;
      out_valid_r  <= 1'b0;
      step_r       <= 2'd0;
      row_r        <= 4'd0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      gaze_r       <= gaze_nxt;
      start_r      <= start_nxt;
      radius_r     <= radius_nxt;
      shift_r      <= shift_nxt;
      greet_r      <= greet_nxt;
      contracted_r <= contracted_nxt;
      out_valid_r  <= out_valid_nxt;
      step_r       <= step_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    now_r      <= now_nxt;
    elapsed_r  <= elapsed_nxt;
    act_r      <= act_nxt;
    clip_r     <= clip_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    out_row_r  <= out_row_nxt;
    out_pix_r  <= out_pix_nxt;
    out_act_r  <= out_act_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 16'd200;
      hold_r   <= 16'd1000;
      close_r  <= 16'd200;
      gopen_r  <= 16'd400;
      ghold_r  <= 16'd2000;
      gclose_r <= 16'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OPEN:        open_r   <= cfg_data;
        CFG_HOLD:        hold_r   <= cfg_data;
        CFG_CLOSE:       close_r  <= cfg_data;
        CFG_GREET_OPEN:  gopen_r  <= cfg_data;
        CFG_GREET_HOLD:  ghold_r  <= cfg_data;
        CFG_GREET_CLOSE: gclose_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  `EBAR_ASSERT_IMP(a_no_take_while_busy, clk, rst_n, in_tready, !out_tvalid)
  `EBAR_ASSERT_NXT(a_last_ends_burst, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)
  `EBAR_ASSERT_NXT(a_burst_continues, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid)
  `EBAR_ASSERT_IMP(a_inactive_blank, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[35:4] == 32'd0)
  `EBAR_ASSERT_IMP(a_last_on_row15, clk, rst_n, out_tvalid, out_tlast == (out_tdata[3:0] == 4'd15))

endmodule

[tb/tb_eye_blink_animation_renderer.sv]
// ----------------------------------------------------------------------------
// Eye blink animation renderer testbench
// Streams begin, touch, update and render requests into the renderer with
// random gaps and output stalls, predicts the sixteen row bitmaps of every
// render from a behavioural eye model, and checks each row as it leaves.
// ----------------------------------------------------------------------------
module tb_eye_blink_animation_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import ebar_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_WAIT = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  gaze;
    logic        greet;
    logic [2:0]  rnd;
    logic [31:0] now;
  } glance_req_t;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [31:0] pixels;
    logic        active;
    logic        last;
  } eye_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  eye_blink_animation_renderer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // eye state as the renderer should hold it
  logic [15:0] dur_reg [6];
  phase_t      eye_phase = PH_IDLE;
  logic [1:0]  gaze_dir = 2'd0;
  logic [31:0] phase_t0 = '0;
  logic [2:0]  pupil_r = 3'd3;
  int          pupil_dy = 0;
  logic        greet_mode = 1'b0;
  logic        contracted = 1'b0;

  glance_req_t req_pending[$];
  eye_row_t    frame_rows_due[$];
  glance_req_t cur_req;
  eye_row_t    got_row;
  eye_row_t    want_row;
  int          in_wait = 0;
  int          out_wait = 0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;

  initial begin
    dur_reg[CFG_OPEN]        = 16'd200;
    dur_reg[CFG_HOLD]        = 16'd1000;
    dur_reg[CFG_CLOSE]       = 16'd200;
    dur_reg[CFG_GREET_OPEN]  = 16'd400;
    dur_reg[CFG_GREET_HOLD]  = 16'd2000;
    dur_reg[CFG_GREET_CLOSE] = 16'd400;
  end

  function automatic logic [15:0] open_dur();
    return greet_mode ? dur_reg[CFG_GREET_OPEN] : dur_reg[CFG_OPEN];
  endfunction

  function automatic logic [15:0] hold_dur();
    return greet_mode ? dur_reg[CFG_GREET_HOLD] : dur_reg[CFG_HOLD];
  endfunction

  function automatic logic [15:0] close_dur();
    return greet_mode ? dur_reg[CFG_GREET_CLOSE] : dur_reg[CFG_CLOSE];
  endfunction

  function automatic int gaze_shift(logic [1:0] g);
    if (g == GZ_LEFT) return -3;
    if (g == GZ_RIGHT) return 3;
    return 0;
  endfunction

  task automatic step_phase(logic [31:0] now);
    logic [31:0] el;
    logic [15:0] hold;
    el = now - phase_t0;
    case (eye_phase)
      PH_OPENING: begin
        if (el >= open_dur()) begin
          eye_phase = PH_OPEN;
          phase_t0 = now;
        end
      end
      PH_OPEN: begin
        hold = hold_dur();
        // contract the pupil once, in the last stretch of a greeting hold
        if (greet_mode && !contracted && hold >= CONTRACT_LEAD &&
            el >= hold - CONTRACT_LEAD) begin
          contracted = 1'b1;
          if (pupil_r > 3'd2) pupil_r = pupil_r - 3'd1;
        end
        if (el >= hold) begin
          eye_phase = PH_CLOSING;
          phase_t0 = now;
        end
      end
      PH_CLOSING: begin
        if (el >= close_dur()) eye_phase = PH_FINISHED;
      end
      default: ;
    endcase
  endtask

  function automatic int clip_rows(logic [31:0] now);
    logic [31:0] el;
    longint unsigned e;
    longint unsigned d;
    el = now - phase_t0;
    e = el;
    if (eye_phase == PH_OPENING) begin
      d = open_dur();
      if (d == 0 || e >= d) return 0;
      return int'((8 * (d - e)) / d);
    end
    if (eye_phase == PH_CLOSING) begin
      d = close_dur();
      if (d == 0) return 0;
      if (e >= d) return 8;
      return int'((8 * e) / d);
    end
    return 0;
  endfunction

  function automatic logic [31:0] eye_row_bits(int y, int top, int bottom);
    logic [31:0] bits;
    int pcx, pcy, r, dx, dy, px, py;
    logic lit;
    bits = '0;
    if (y < top || y > bottom) return bits;
    pcx = 15 + gaze_shift(gaze_dir);
    pcy = 7 + pupil_dy;
    r = int'(pupil_r);
    for (int x = 0; x < COLUMNS && x < 32; x++) begin
      dx = x - 15;
      dy = y - 7;
      px = x - pcx;
      py = y - pcy;
      // sclera ring outside the iris, then the pupil on top
      lit = (dx * dx + 4 * dy * dy <= 196) && !(dx * dx + dy * dy <= 36);
      if (px * px + py * py <= r * r) lit = 1'b1;
      bits[x] = lit;
    end
    return bits;
  endfunction

  task automatic advance_eye(glance_req_t rq);
    logic act;
    int clip;
    eye_row_t row;
    case (rq.func)
      FN_BEGIN: begin
        gaze_dir = rq.gaze;
        greet_mode = rq.greet;
        eye_phase = PH_OPENING;
        phase_t0 = rq.now;
        contracted = 1'b0;
        pupil_r = 3'd3 + {2'b0, rq.rnd[0]};
        pupil_dy = int'(rq.rnd[2:1]) - 1;
      end
      FN_TOUCH: begin
        gaze_dir = rq.gaze;
        eye_phase = PH_OPENING;
        phase_t0 = rq.now;
        contracted = 1'b0;
        if (greet_mode && pupil_r < 3'd3) pupil_r = 3'd3;
      end
      default: begin
        step_phase(rq.now);
        if (rq.func == FN_RENDER) begin
          act = (eye_phase == PH_OPENING) || (eye_phase == PH_OPEN) ||
                (eye_phase == PH_CLOSING);
          clip = act ? clip_rows(rq.now) : 8;
          for (int y = 0; y < 16; y++) begin
            row.row_index = 4'(y);
            row.pixels = act ? eye_row_bits(y, clip, 15 - clip) : '0;
            row.active = act;
            row.last = (y == 15);
            frame_rows_due.push_back(row);
          end
        end
      end
    endcase
  endtask

  function automatic int draw_wait(logic calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_eye(cur_req);
        in_wait = draw_wait(in_calm);
      end
      if ((in_tvalid && in_tready) || !in_tvalid) begin
        if (in_wait == 0 && req_pending.size() != 0) begin
          cur_req = req_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cur_req.now, cur_req.rnd, cur_req.greet, cur_req.gaze};
          in_tuser <= cur_req.func;
        end else begin
          in_tvalid <= 1'b0;
          if (in_wait != 0) in_wait--;
        end
      end
    end
  end

  task automatic report_miss(string msg);
    if (mismatches < 10) $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // row monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_row.row_index = out_tdata[3:0];
        got_row.pixels = out_tdata[35:4];
        got_row.active = out_tuser[0];
        got_row.last = out_tlast;
        if (frame_rows_due.size() == 0) begin
          report_miss($sformatf("row %0d with no render pending", got_row.row_index));
        end else begin
          want_row = frame_rows_due.pop_front();
          if (got_row.row_index !== want_row.row_index)
            report_miss($sformatf("row_index exp %0d got %0d",
                                  want_row.row_index, got_row.row_index));
          if (got_row.pixels !== want_row.pixels)
            report_miss($sformatf("row %0d pixel_row exp %h got %h",
                                  want_row.row_index, want_row.pixels, got_row.pixels));
          if (got_row.active !== want_row.active)
            report_miss($sformatf("row %0d active exp %0b got %0b",
                                  want_row.row_index, want_row.active, got_row.active));
          if (got_row.last !== want_row.last)
            report_miss($sformatf("row %0d last exp %0b got %0b",
                                  want_row.row_index, want_row.last, got_row.last));
        end
        out_wait = draw_wait(out_calm);
      end
      if (out_wait != 0) begin
        out_tready <= 1'b0;
        out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // switch between gappy traffic and back-to-back stretches now and then
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) begin
      in_calm <= ($urandom_range(0, 2) == 0);
      out_calm <= ($urandom_range(0, 2) == 0);
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_eye_blink_animation_renderer: FAIL");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] func, logic [1:0] gaze, logic greet,
                          logic [2:0] rnd, logic [31:0] now);
    glance_req_t r;
    r.func = func;
    r.gaze = gaze;
    r.greet = greet;
    r.rnd = rnd;
    r.now = now;
    req_pending.push_back(r);
  endtask

  // hold until every request is taken and every row has left, then let the
  // block finish any update still in flight
  task automatic drain();
    wait (req_pending.size() == 0 && !in_tvalid && frame_rows_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_GREET_CLOSE) dur_reg[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_durations(logic [15:0] o, logic [15:0] h, logic [15:0] c,
                               logic [15:0] go, logic [15:0] gh, logic [15:0] gc);
    write_reg(CFG_OPEN, o);
    write_reg(CFG_HOLD, h);
    write_reg(CFG_CLOSE, c);
    write_reg(CFG_GREET_OPEN, go);
    write_reg(CFG_GREET_HOLD, gh);
    write_reg(CFG_GREET_CLOSE, gc);
  endtask

  // one begin followed by a run of updates, renders and touches at rising times
  task automatic queue_glance(ref int queued);
    logic [1:0] gz;
    logic greet;
    logic [31:0] t;
    int span;
    int k;
    gz = 2'($urandom_range(0, 3));
    greet = 1'($urandom_range(0, 1));
    t = $urandom;
    push_req(FN_BEGIN, gz, greet, 3'($urandom_range(0, 7)), t);
    if (greet)
      span = dur_reg[CFG_GREET_OPEN] + dur_reg[CFG_GREET_HOLD] + dur_reg[CFG_GREET_CLOSE];
    else
      span = dur_reg[CFG_OPEN] + dur_reg[CFG_HOLD] + dur_reg[CFG_CLOSE];
    queued++;
    repeat ($urandom_range(5, 10)) begin
      t = t + $urandom_range(0, span / 5 + 2);
      k = $urandom_range(0, 9);
      push_req(k < 7 ? FN_RENDER : (k < 9 ? FN_UPDATE : FN_TOUCH),
               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               3'($urandom_range(0, 7)), t);
      queued++;
    end
  endtask

  task automatic queue_random(int target);
    int queued;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom);
        queued++;
      end else begin
        queue_glance(queued);
      end
    end
  endtask

  localparam logic [31:0] WRAP_T0 = 32'hFFFF_FF00;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset durations
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd0);        // render before any begin
    push_req(FN_UPDATE, 2'd0, 1'b0, 3'd0, 32'd5);
    push_req(FN_BEGIN, GZ_LEFT, 1'b0, 3'd0, 32'd100);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd100);      // fully clipped
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd200);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd300);      // opening done
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd1300);     // into closing
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd1450);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd1500);     // finished
    push_req(FN_BEGIN, GZ_RIGHT, 1'b1, 3'd6, WRAP_T0);   // greeting, time wraps
    push_req(FN_UPDATE, 2'd0, 1'b0, 3'd0, WRAP_T0 + 32'd400);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, WRAP_T0 + 32'd2250); // pupil contracts
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, WRAP_T0 + 32'd2400);
    push_req(FN_TOUCH, 2'd3, 1'b0, 3'd0, WRAP_T0 + 32'd2500);  // gaze three
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, WRAP_T0 + 32'd2900);
    push_req(FN_BEGIN, 2'd0, 1'b0, 3'd3, 32'hFFFF_FFFF);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd50);
    push_req(FN_UPDATE, 2'd0, 1'b0, 3'd0, 32'd250);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd260);
    push_req(FN_BEGIN, 2'd0, 1'b1, 3'd5, 32'd0);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd1);
    push_req(FN_TOUCH, GZ_LEFT, 1'b0, 3'd7, 32'd2);
    push_req(FN_RENDER, 2'd0, 1'b0, 3'd0, 32'd402);
    drain();

    // moderate random durations
    set_durations(16'($urandom_range(1, 400)), 16'($urandom_range(0, 900)),
                  16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                  16'($urandom_range(150, 900)), 16'($urandom_range(1, 400)));
    queue_random(15);
    drain();
    queue_random(15);
    drain();

    // extremes of the duration range; an unused index must change nothing
    set_durations(16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    write_reg(CFG_UNUSED, 16'($urandom));
    queue_random(30);
    drain();

    // zero durations and a greeting hold too short to contract
    set_durations(16'd0, 16'd300, 16'd0, 16'd0, 16'd100, 16'd0);
    queue_random(30);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_eye_blink_animation_renderer: PASS");
    end else begin
      $display("tb_eye_blink_animation_renderer: FAIL");
    end
    $finish;
  end

endmodule
